FILE: design/emm_pkg.sv
// shared types, register indexes and decode functions of the extended register file
// and memory mapper; used by emm_mirror and ext_register_file_memory_mapper
package emm_pkg;

   localparam int unsigned REG_COUNT = 256;
   localparam int unsigned REG_WIDTH = 8;

   localparam logic [7:0] REG_VCONFIG   = 8'h00;
   localparam logic [7:0] REG_PAGE0     = 8'h10;
   localparam logic [7:0] REG_PAGE1     = 8'h11;
   localparam logic [7:0] REG_PAGE2     = 8'h12;
   localparam logic [7:0] REG_PAGE3     = 8'h13;
   localparam logic [7:0] REG_SYSCONFIG = 8'h20;
   localparam logic [7:0] REG_MEMCONFIG = 8'h21;

   localparam logic [1:0] KIND_WRITE_REG  = 2'd0;
   localparam logic [1:0] KIND_READ_REG   = 2'd1;
   localparam logic [1:0] KIND_WRITE_PORT = 2'd2;

   localparam logic [8:0] FULL_WIDTH    = 9'd360;
   localparam logic [8:0] FULL_HEIGHT   = 9'd288;
   localparam logic [4:0] ROM_PAGE_MASK = 5'd31;

   typedef struct packed {
      logic [1:0] size_sel;
      logic [1:0] video_mode;
      logic [7:0] page0;
      logic [7:0] page1;
      logic [7:0] page2;
      logic [7:0] page3;
      logic [1:0] turbo_sel;
      logic       mem_ram;
      logic       mem_nomap;
      logic       shadow_bit4;
   } map_type;

   function automatic logic [7:0] reg_default(input logic [7:0] idx);
      logic [7:0] v;
      case (idx)
         8'h01, REG_PAGE1: v = 8'd5;
         8'h07:            v = 8'd15;
         REG_PAGE2:        v = 8'd2;
         REG_MEMCONFIG:    v = 8'd4;
         REG_SYSCONFIG, 8'h22, 8'h2A: v = 8'd1;
         default:          v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic logic [8:0] size_width(input logic [1:0] sel);
      logic [8:0] v;
      case (sel)
         2'd0:    v = 9'd256;
         2'd1:    v = 9'd320;
         2'd2:    v = 9'd320;
         default: v = 9'd360;
      endcase
      return v;
   endfunction

   function automatic logic [8:0] size_height(input logic [1:0] sel);
      logic [8:0] v;
      case (sel)
         2'd0:    v = 9'd192;
         2'd1:    v = 9'd200;
         2'd2:    v = 9'd240;
         default: v = 9'd288;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] turbo_decode(input logic [1:0] sel);
      logic [2:0] v;
      case (sel)
         2'd0:    v = 3'd1;
         2'd1:    v = 3'd2;
         default: v = 3'd4;
      endcase
      return v;
   endfunction

endpackage

FILE: design/emm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module emm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/emm_mirror.sv
// copies of the mapping, video and turbo registers plus the legacy port shadow bit
// depends on emm_pkg
module emm_mirror (
   input  logic            clock,
   input  logic            reset,
   input  logic            beat,
   input  logic [1:0]      kind,
   input  logic [7:0]      reg_index,
   input  logic [7:0]      write_value,
   output emm_pkg::map_type map
);

   emm_pkg::map_type map_ff;
   emm_pkg::map_type map_in;

   always_comb begin
      map_in = map_ff;
      if (beat && kind == emm_pkg::KIND_WRITE_REG) begin
         case (reg_index)
            emm_pkg::REG_VCONFIG: begin
               map_in.size_sel   = write_value[7:6];
               map_in.video_mode = write_value[1:0];
            end
            emm_pkg::REG_PAGE0: map_in.page0 = write_value;
            emm_pkg::REG_PAGE1: map_in.page1 = write_value;
            emm_pkg::REG_PAGE2: map_in.page2 = write_value;
            emm_pkg::REG_PAGE3: begin
               map_in.page3       = write_value;
               map_in.shadow_bit4 = write_value[4];
            end
            emm_pkg::REG_SYSCONFIG: map_in.turbo_sel = write_value[1:0];
            emm_pkg::REG_MEMCONFIG: begin
               map_in.mem_ram     = write_value[3];
               map_in.mem_nomap   = write_value[2];
               map_in.shadow_bit4 = write_value[0];
            end
            default: ;
         endcase
      end else if (beat && kind == emm_pkg::KIND_WRITE_PORT) begin
         map_in.shadow_bit4 = write_value[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff.size_sel    <= 2'd0;
         map_ff.video_mode  <= 2'd0;
         map_ff.page0       <= emm_pkg::reg_default(emm_pkg::REG_PAGE0);
         map_ff.page1       <= emm_pkg::reg_default(emm_pkg::REG_PAGE1);
         map_ff.page2       <= emm_pkg::reg_default(emm_pkg::REG_PAGE2);
         map_ff.page3       <= emm_pkg::reg_default(emm_pkg::REG_PAGE3);
         map_ff.turbo_sel   <= 2'd1;
         map_ff.mem_ram     <= 1'b0;
         map_ff.mem_nomap   <= 1'b1;
         map_ff.shadow_bit4 <= 1'b0;
      end else begin
         map_ff <= map_in;
      end
   end

   assign map = map_ff;

endmodule

FILE: design/ext_register_file_memory_mapper.sv
// Extended register file and memory mapper. An item is taken on every cycle in which no
// item is pending or the response register is free or being drained; the pending item
// then moves to the response register, so the sustained rate is one item per clock while
// rsp_ready holds. Register defaults of the 256x8 ram come from per-entry valid bits
// cleared by reset, so no clearing pass is needed and items are taken right after reset.
// depends on emm_pkg, emm_ram, emm_mirror
module ext_register_file_memory_mapper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_reg_index,
   input  logic [7:0] req_write_value,
   input  logic       req_dos_active,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_win0_page,
   output logic       rsp_win0_is_ram,
   output logic [7:0] rsp_win1_page,
   output logic [7:0] rsp_win2_page,
   output logic [7:0] rsp_win3_page,
   output logic [8:0] rsp_pixel_width,
   output logic [8:0] rsp_pixel_height,
   output logic [5:0] rsp_border_width,
   output logic [5:0] rsp_border_height,
   output logic [2:0] rsp_turbo_factor,
   output logic [1:0] rsp_video_mode,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   logic                          beat;
   logic                          out_free;
   logic                          finish;
   logic                          ram_wr;
   logic                          ram_rd;
   logic [7:0]                    ram_q;
   emm_pkg::map_type              map;

   logic                          busy_ff, busy_in;
   logic                          pend_read_ff;
   logic                          pend_dos_ff;
   logic                          pend_vld_ff;
   logic [7:0]                    pend_default_ff;
   logic [emm_pkg::REG_COUNT-1:0] vld_ff, vld_in;
   logic                          sysrom_ff, sysrom_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [7:0] read_data_ff, read_data_in;
   logic [7:0] win0_ff, win0_in;
   logic       win0_ram_ff;
   logic [7:0] win1_ff, win2_ff, win3_ff;
   logic [8:0] width_ff, width_in;
   logic [8:0] height_ff, height_in;
   logic [5:0] bwidth_ff, bwidth_in;
   logic [5:0] bheight_ff, bheight_in;
   logic [2:0] turbo_ff;
   logic [1:0] vmode_ff;
   logic [1:0] rom_low;
   logic [8:0] bw_full;
   logic [8:0] bh_full;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = busy_ff && out_free;
   assign req_ready = !busy_ff || out_free;
   assign beat      = req_valid && req_ready;
   assign ram_wr    = beat && req_kind == emm_pkg::KIND_WRITE_REG;
   assign ram_rd    = beat && req_kind == emm_pkg::KIND_READ_REG;

   emm_ram #(
      .WIDTH (emm_pkg::REG_WIDTH),
      .DEPTH (emm_pkg::REG_COUNT)
   ) u_regs (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (req_reg_index),
      .wr_data (req_write_value),
      .rd_en   (ram_rd),
      .rd_addr (req_reg_index),
      .rd_data (ram_q)
   );

   emm_mirror u_mirror (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .kind        (req_kind),
      .reg_index   (req_reg_index),
      .write_value (req_write_value),
      .map         (map)
   );

   always_comb begin
      busy_in = beat ? 1'b1 : (finish ? 1'b0 : busy_ff);
      vld_in  = vld_ff;
      if (ram_wr) begin
         vld_in[req_reg_index] = 1'b1;
      end
      sysrom_in = csr_write_enable ? csr_write_data : sysrom_ff;
      rsp_valid_in = finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      if (sysrom_ff) begin
         rom_low = 2'b00;
      end else if (pend_dos_ff) begin
         rom_low = 2'b01;
      end else begin
         rom_low = {1'b1, map.shadow_bit4};
      end
      if (map.mem_nomap) begin
         win0_in = {3'b000, map.page0[4:0] & emm_pkg::ROM_PAGE_MASK};
      end else begin
         win0_in = {map.page0[5:0], rom_low};
      end

      if (!pend_read_ff) begin
         read_data_in = 8'd0;
      end else if (pend_vld_ff) begin
         read_data_in = ram_q;
      end else begin
         read_data_in = pend_default_ff;
      end

      width_in   = emm_pkg::size_width(map.size_sel);
      height_in  = emm_pkg::size_height(map.size_sel);
      bw_full    = (emm_pkg::FULL_WIDTH - width_in) >> 1;
      bh_full    = (emm_pkg::FULL_HEIGHT - height_in) >> 1;
      bwidth_in  = bw_full[5:0];
      bheight_in = bh_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         vld_ff       <= '0;
         sysrom_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         vld_ff       <= vld_in;
         sysrom_ff    <= sysrom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         pend_read_ff    <= req_kind == emm_pkg::KIND_READ_REG;
         pend_dos_ff     <= req_dos_active;
         pend_vld_ff     <= vld_ff[req_reg_index];
         pend_default_ff <= emm_pkg::reg_default(req_reg_index);
      end
      if (finish) begin
         read_data_ff <= read_data_in;
         win0_ff      <= win0_in;
         win0_ram_ff  <= map.mem_ram;
         win1_ff      <= map.page1;
         win2_ff      <= map.page2;
         win3_ff      <= map.page3;
         width_ff     <= width_in;
         height_ff    <= height_in;
         bwidth_ff    <= bwidth_in;
         bheight_ff   <= bheight_in;
         turbo_ff     <= emm_pkg::turbo_decode(map.turbo_sel);
         vmode_ff     <= map.video_mode;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_win0_page     = win0_ff;
   assign rsp_win0_is_ram   = win0_ram_ff;
   assign rsp_win1_page     = win1_ff;
   assign rsp_win2_page     = win2_ff;
   assign rsp_win3_page     = win3_ff;
   assign rsp_pixel_width   = width_ff;
   assign rsp_pixel_height  = height_ff;
   assign rsp_border_width  = bwidth_ff;
   assign rsp_border_height = bheight_ff;
   assign rsp_turbo_factor  = turbo_ff;
   assign rsp_video_mode    = vmode_ff;

`ifndef SYNTHESIS
   // a new response only follows a pending item
   a_rsp_after_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response raised with no pending item");

   // a stalled pending item is kept
   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !out_free |=> busy_ff)
      else $error("pending item dropped under stall");

   // turbo factor is always a single power of two
   a_turbo_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot(rsp_turbo_factor))
      else $error("turbo factor not a power of two");

   // memconfig writes reach the mapping copy
   a_memcfg_mirror: assert property (@(posedge clock) disable iff (reset)
      ram_wr && req_reg_index == emm_pkg::REG_MEMCONFIG
      |=> map.mem_nomap == $past(req_write_value[2]) && map.shadow_bit4 == $past(req_write_value[0]))
      else $error("memconfig copy out of step");
`endif

endmodule
